@@ sv/cit_pkg.sv @@
// Package: sizes, codes and shared types of the compacting id table.
package cit_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 32;
  localparam int NAME_W   = 64;
  localparam int ENTRY_W  = ID_W + NAME_W;

  typedef enum logic [1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_LIST = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_ADDED      = 3'd0,
    ST_FULL       = 3'd1,
    ST_DELETED    = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_LIST_ENTRY = 3'd4,
    ST_LIST_EMPTY = 3'd5
  } status_e;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [NAME_W-1:0] name;
  } entry_t;

  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     entry_id;
    logic [NAME_W-1:0]   entry_data;
    logic                last;
  } rsp_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } mem_wr_t;

endpackage

@@ sv/cit_if.sv @@
// Interfaces: request and response channels of the compacting id table.
interface cit_req_if import cit_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic signed [ID_W-1:0]   file_id;
  logic [NAME_W-1:0]        name_data;

  modport source (output valid, kind, file_id, name_data, input ready);
  modport sink   (input valid, kind, file_id, name_data, output ready);
endinterface

interface cit_rsp_if import cit_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic signed [ID_W-1:0]   entry_id;
  logic [NAME_W-1:0]        entry_data;
  logic                     last;

  modport source (output valid, status, entry_id, entry_data, last, input ready);
  modport sink   (input valid, status, entry_id, entry_data, last, output ready);
endinterface

@@ sv/cit_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/cit_out_stage.sv @@
// Output register: holds one result beat until the receiver takes it.
module cit_out_stage import cit_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  rsp_t res_i,
  input  logic ready_i,
  output logic valid_o,
  output rsp_t res_o,
  output logic free_o
);

  logic valid_q, valid_d;
  rsp_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ sv/cit_ctrl.sv @@
// Sequencer: add, search/shift delete and list walk over the entry RAM.
module cit_ctrl import cit_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  logic [1:0]        req_kind_i,
  input  logic [ID_W-1:0]   req_id_i,
  input  logic [NAME_W-1:0] req_name_i,
  input  logic              out_free_i,
  output logic              res_valid_o,
  output rsp_t              res_o,
  output logic [IDX_W-1:0]  mem_raddr_o,
  input  entry_t            mem_rdata_i,
  output mem_wr_t           mem_wr_o
);

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_SHIFT, S_LIST} state_e;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [ID_W-1:0]   key_q, key_d;

  logic              accept;
  logic [CNT_W-1:0]  idx_ext;
  logic              hit;

  assign req_ready_o = (state_q == S_IDLE) && out_free_i;
  assign accept      = req_valid_i && req_ready_o;
  assign idx_ext     = CNT_W'(idx_q);
  assign hit         = (mem_rdata_i.id == key_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    key_d       = key_q;
    mem_raddr_o = idx_q;          // re-read same entry while stalled
    mem_wr_o    = '{we: 1'b0, addr: idx_q, data: mem_rdata_i};
    res_valid_o = 1'b0;
    res_o       = '{status: ST_ADDED, entry_id: '0, entry_data: '0, last: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          mem_raddr_o = '0;
          idx_d       = '0;
          unique case (kind_e'(req_kind_i))
            KIND_ADD: begin
              res_valid_o    = 1'b1;
              res_o.entry_id = req_id_i;
              if (cnt_q < CNT_W'(CAPACITY)) begin
                mem_wr_o = '{we: 1'b1, addr: cnt_q[IDX_W-1:0],
                             data: '{id: req_id_i, name: req_name_i}};
                cnt_d    = cnt_q + CNT_W'(1);
              end else begin
                res_o.status = ST_FULL;
              end
            end
            KIND_DEL: begin
              key_d = req_id_i;
              if (cnt_q == '0) begin
                res_valid_o    = 1'b1;
                res_o.status   = ST_NOT_FOUND;
                res_o.entry_id = req_id_i;
              end else begin
                state_d = S_SEARCH;
              end
            end
            KIND_LIST: begin
              if (cnt_q == '0) begin
                res_valid_o  = 1'b1;
                res_o.status = ST_LIST_EMPTY;
              end else begin
                state_d = S_LIST;
              end
            end
            default: ;
          endcase
        end
      end

      S_SEARCH: begin
        if (hit) begin
          if (out_free_i) begin
            res_valid_o      = 1'b1;
            res_o.status     = ST_DELETED;
            res_o.entry_id   = mem_rdata_i.id;
            res_o.entry_data = mem_rdata_i.name;
            if (idx_ext + CNT_W'(1) < cnt_q) begin
              mem_raddr_o = idx_q + IDX_W'(1);
              state_d     = S_SHIFT;
            end else begin
              cnt_d   = cnt_q - CNT_W'(1);
              state_d = S_IDLE;
            end
          end
        end else if (idx_ext + CNT_W'(1) == cnt_q) begin
          if (out_free_i) begin
            res_valid_o    = 1'b1;
            res_o.status   = ST_NOT_FOUND;
            res_o.entry_id = key_q;
            state_d        = S_IDLE;
          end
        end else begin
          idx_d       = idx_q + IDX_W'(1);
          mem_raddr_o = idx_q + IDX_W'(1);
        end
      end

      S_SHIFT: begin
        // read data is entry idx+1; it moves down to idx
        mem_wr_o.we = 1'b1;
        if (idx_ext + CNT_W'(2) < cnt_q) begin
          idx_d       = idx_q + IDX_W'(1);
          mem_raddr_o = IDX_W'(idx_ext + CNT_W'(2));
        end else begin
          cnt_d   = cnt_q - CNT_W'(1);
          state_d = S_IDLE;
        end
      end

      S_LIST: begin
        if (out_free_i) begin
          res_valid_o      = 1'b1;
          res_o.status     = ST_LIST_ENTRY;
          res_o.entry_id   = mem_rdata_i.id;
          res_o.entry_data = mem_rdata_i.name;
          res_o.last       = (idx_ext + CNT_W'(1) == cnt_q);
          if (idx_ext + CNT_W'(1) == cnt_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d       = idx_q + IDX_W'(1);
            mem_raddr_o = idx_q + IDX_W'(1);
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      key_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      key_q   <= key_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> out_free_i)
    else $error("result emitted into a busy output register");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (CNT_W'(mem_wr_o.addr) + CNT_W'(1) < cnt_q))
    else $error("shift writes outside the live entries");

  a_del_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && state_d == S_IDLE) |=>
      (cnt_q == $past(cnt_q) - CNT_W'(1)))
    else $error("delete did not shrink the table");

endmodule

@@ sv/compacting_id_table_top.sv @@
// Top level of the compacting id table: entry RAM, sequencer, output register.
//
// Usage:
//   req_i carries one command beat: kind (add, delete by id, list), file_id
//   and name_data. rsp_o returns result beats: status, entry_id, entry_data
//   and last, which marks the final beat caused by a command.
//   Entries live in one RAM (id and name word side by side), depth CAPACITY,
//   one write and one registered read port. The entry count is a register.
//   Add: one beat, issued in the accept cycle, visible the next cycle.
//   Delete: a search reads one entry per cycle, the matching entry goes out
//   as the result, then later entries move down one place per cycle. A delete
//   on an empty table gives a not-found beat without a search.
//   List: one beat per cycle while the output register is free, read from the
//   registered RAM port; an empty table gives one beat.
//   Unused kind codes are accepted and dropped.
//   One command is in work at a time; req_i.ready is high only when the
//   sequencer is idle and the output register can take a beat.
//   A stalled receiver holds the output register; the sequencer re-reads the
//   same entry and waits, so no beat is lost or repeated.
//   Reset clears the entry count; RAM contents are left as they are.
module compacting_id_table_top import cit_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  cit_req_if.sink    req_i,
  cit_rsp_if.source  rsp_o
);

  logic             out_free;
  logic             res_valid;
  rsp_t             res;
  rsp_t             out_res;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;
  mem_wr_t          mem_wr;

  cit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_kind_i  (req_i.kind),
    .req_id_i    (req_i.file_id),
    .req_name_i  (req_i.name_data),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .mem_wr_o    (mem_wr)
  );

  // Entry store: id in the upper bits, name word in the lower bits.
  cit_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (mem_wr.we),
    .waddr_i (mem_wr.addr),
    .wdata_i (mem_wr.data),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  cit_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .ready_i (rsp_o.ready),
    .valid_o (rsp_o.valid),
    .res_o   (out_res),
    .free_o  (out_free)
  );

  assign rsp_o.status     = out_res.status;
  assign rsp_o.entry_id   = out_res.entry_id;
  assign rsp_o.entry_data = out_res.entry_data;
  assign rsp_o.last       = out_res.last;

endmodule
